FILE: design/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

    // default table size
    localparam int TABLE_DEPTH_DEF = 16;

    // result kinds
    localparam logic [1:0] KIND_FIRED    = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_DROPPED  = 2'd2;

    // one scheduled command as stored in the table
    typedef struct packed {
        logic [1:0]  cmd_type;
        logic [15:0] target;
        logic [31:0] payload;
        logic [15:0] delay_left;
        logic [15:0] countdown;
        logic [15:0] period;
        logic [15:0] limit;
        logic [15:0] runs;
    } entry_t;

endpackage

`default_nettype wire

FILE: design/pcs_table.sv
`timescale 1ns / 1ps
`default_nettype none

module pcs_table #(
    parameter int DEPTH = pcs_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire pcs_pkg::entry_t   wr_data,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output pcs_pkg::entry_t        rd_data
);

    pcs_pkg::entry_t mem [DEPTH];
    pcs_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/periodic_command_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Periodic command scheduler: keeps up to TABLE_DEPTH commands in a single
// one-port-read table memory. A beat with s_mode = 1 enqueues a command and is
// answered by one result beat (accepted, or dropped when the table is full).
// A beat with s_mode = 0 is a frame tick that walks the live entries in table
// order: an entry that is still counting down is read, then written back, and
// a firing entry the same; an entry that reaches its run limit with live
// entries behind it also has the last entry pulled into its slot, which is
// then visited again. The walk ends with a flush step. A tick with no firing
// gives no result beat; the last firing of a tick carries m_last = 1. Result
// beats wait in an output register, and the walk stalls only when a held-back
// firing must be passed on (at a new firing or at the flush) while it is full.
// s_ready is high only while no item is in progress.
module periodic_command_scheduler #(
    parameter int TABLE_DEPTH = pcs_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [1:0]  s_cmd_type,
    input  wire logic [15:0] s_target_id,
    input  wire logic [31:0] s_payload,
    input  wire logic [15:0] s_start_delay,
    input  wire logic [15:0] s_period,
    input  wire logic [15:0] s_repeat_limit,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [1:0]       m_fired_type,
    output logic [15:0]      m_fired_target,
    output logic [31:0]      m_fired_payload,
    output logic             m_last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // walk sequencer, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ENQ   = 6'b000010,
        S_RD    = 6'b000100,
        S_EVAL  = 6'b001000,
        S_MOVE  = 6'b010000,
        S_FLUSH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    // captured enqueue beat
    logic [1:0]  enq_type_reg;
    logic [15:0] enq_target_reg;
    logic [31:0] enq_payload_reg;
    logic [15:0] enq_delay_reg;
    logic [15:0] enq_period_reg;
    logic [15:0] enq_limit_reg;

    // last firing of the walk, held back until we know whether it is final
    logic        held_valid_reg, held_valid_next;
    logic [1:0]  held_type_reg;
    logic [15:0] held_target_reg;
    logic [31:0] held_payload_reg;
    logic        held_load;

    // output register
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [1:0]  m_type_reg;
    logic [15:0] m_target_reg;
    logic [31:0] m_payload_reg;
    logic        m_last_reg;

    logic        out_free;
    logic        push;
    logic [1:0]  push_kind;
    logic [1:0]  push_type;
    logic [15:0] push_target;
    logic [31:0] push_payload;
    logic        push_last;

    // table port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    pcs_pkg::entry_t  wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    pcs_pkg::entry_t  rd_data;

    logic             in_beat;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] tail_idx;
    logic [15:0]      runs_new;

    pcs_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_inc  = idx_reg + CNT_ONE;
    assign tail_idx = count_reg - CNT_ONE;
    // run count saturates at all ones
    assign runs_new = (rd_data.runs == 16'hFFFF) ? rd_data.runs : rd_data.runs + 16'd1;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        held_valid_next = held_valid_reg;
        held_load       = 1'b0;

        push         = 1'b0;
        push_kind    = pcs_pkg::KIND_FIRED;
        push_type    = 2'd0;
        push_target  = 16'd0;
        push_payload = 32'd0;
        push_last    = 1'b0;

        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    if (s_mode) begin
                        state_next = S_ENQ;
                    end else begin
                        idx_next = '0;
                        // empty table: a tick gives nothing
                        state_next = (count_reg == '0) ? S_IDLE : S_RD;
                    end
                end
            end

            S_ENQ: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg == CNT_FULL) begin
                        push_kind = pcs_pkg::KIND_DROPPED;
                    end else begin
                        push_kind          = pcs_pkg::KIND_ACCEPTED;
                        wr_en              = 1'b1;
                        wr_addr            = count_reg[IDX_W-1:0];
                        wr_data.cmd_type   = enq_type_reg;
                        wr_data.target     = enq_target_reg;
                        wr_data.payload    = enq_payload_reg;
                        wr_data.delay_left = enq_delay_reg;
                        wr_data.countdown  = 16'd0;
                        // zero period is stored as one
                        wr_data.period     = (enq_period_reg == 16'd0) ? 16'd1
                                                                       : enq_period_reg;
                        wr_data.limit      = enq_limit_reg;
                        wr_data.runs       = 16'd0;
                        count_next         = count_reg + CNT_ONE;
                    end
                end
            end

            S_RD: begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL: begin
                priority if (rd_data.delay_left != 16'd0) begin
                    wr_en              = 1'b1;
                    wr_data.delay_left = rd_data.delay_left - 16'd1;
                    idx_next           = idx_inc;
                    state_next         = (idx_inc < count_reg) ? S_RD : S_FLUSH;
                end else if (rd_data.countdown != 16'd0) begin
                    wr_en             = 1'b1;
                    wr_data.countdown = rd_data.countdown - 16'd1;
                    idx_next          = idx_inc;
                    state_next        = (idx_inc < count_reg) ? S_RD : S_FLUSH;
                end else if (!held_valid_reg || out_free) begin
                    // fire: the previous firing is now known not to be the last
                    if (held_valid_reg) begin
                        push         = 1'b1;
                        push_type    = held_type_reg;
                        push_target  = held_target_reg;
                        push_payload = held_payload_reg;
                    end
                    held_load       = 1'b1;
                    held_valid_next = 1'b1;
                    if (runs_new >= rd_data.limit) begin
                        // run limit reached: remove the entry
                        if (idx_reg != tail_idx) begin
                            rd_en      = 1'b1;
                            rd_addr    = tail_idx[IDX_W-1:0];
                            state_next = S_MOVE;
                        end else begin
                            count_next = tail_idx;
                            state_next = S_FLUSH;
                        end
                    end else begin
                        wr_en             = 1'b1;
                        wr_data.countdown = rd_data.period;
                        wr_data.runs      = runs_new;
                        idx_next          = idx_inc;
                        state_next        = (idx_inc < count_reg) ? S_RD : S_FLUSH;
                    end
                end
            end

            S_MOVE: begin
                // last entry fills the freed slot and is visited next
                wr_en      = 1'b1;
                wr_data    = rd_data;
                count_next = tail_idx;
                state_next = S_RD;
            end

            S_FLUSH: begin
                if (!held_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_type       = held_type_reg;
                    push_target     = held_target_reg;
                    push_payload    = held_payload_reg;
                    push_last       = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            held_valid_reg <= held_valid_next;
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            enq_type_reg    <= s_cmd_type;
            enq_target_reg  <= s_target_id;
            enq_payload_reg <= s_payload;
            enq_delay_reg   <= s_start_delay;
            enq_period_reg  <= s_period;
            enq_limit_reg   <= s_repeat_limit;
        end
        if (held_load) begin
            held_type_reg    <= rd_data.cmd_type;
            held_target_reg  <= rd_data.target;
            held_payload_reg <= rd_data.payload;
        end
        if (push) begin
            m_kind_reg    <= push_kind;
            m_type_reg    <= push_type;
            m_target_reg  <= push_target;
            m_payload_reg <= push_payload;
            m_last_reg    <= push_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_fired_type    = m_type_reg;
    assign m_fired_target  = m_target_reg;
    assign m_fired_payload = m_payload_reg;
    assign m_last          = m_last_reg;

endmodule

`default_nettype wire
